>>> hw/rtl/stt_pkg.sv
// stt_pkg: types and constants of the sparse triplet transpose block
// shared by the channel interfaces and the top level; no dependencies
package stt_pkg;

   localparam int MAX_ENTRIES    = 32;
   localparam int INDEX_BITS     = 10;
   localparam int DIM_BITS       = 11;
   localparam int VALUE_BITS     = 32;
   localparam int ADDR_BITS      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS       = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_BITS       = INDEX_BITS + ADDR_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATRIX_ROWS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATRIX_COLS = 1'd1;

   typedef struct packed {
      logic [INDEX_BITS-1:0]        row_index;
      logic [INDEX_BITS-1:0]        col_index;
      logic signed [VALUE_BITS-1:0] entry_value;
   } stt_entry_type;

endpackage

>>> hw/rtl/stt_if.sv
// stt_req_if and stt_rsp_if: valid/ready channels of the transpose block
// depends on stt_pkg for field widths
interface stt_req_if
   import stt_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic [INDEX_BITS-1:0]        row_index;
   logic [INDEX_BITS-1:0]        col_index;
   logic signed [VALUE_BITS-1:0] entry_value;
   logic                         last_entry;

   modport source (output valid, row_index, col_index, entry_value, last_entry,
                   input ready);
   modport sink   (input valid, row_index, col_index, entry_value, last_entry,
                   output ready);
endinterface

interface stt_rsp_if
   import stt_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic                         is_header;
   logic [DIM_BITS-1:0]          out_row;
   logic [DIM_BITS-1:0]          out_col;
   logic signed [VALUE_BITS-1:0] out_value;
   logic                         overflowed;
   logic                         last_result;

   modport source (output valid, is_header, out_row, out_col, out_value, overflowed,
                   last_result, input ready);
   modport sink   (input valid, is_header, out_row, out_col, out_value, overflowed,
                   last_result, output ready);
endinterface

>>> hw/rtl/sparse_triplet_transpose.sv
// sparse_triplet_transpose: loads triplets one word per cycle, then emits a header
// and the entries stably sorted by source column; depends on stt_pkg, stt_if
// timing: one input word per cycle while loading; the header is registered once the
// last word has moved the state to ST_HDR and the output is free; each sorted entry
// then takes one selection scan of the n stored entries through the single store read
// port and the previous- and best-key comparisons, during which input is not ready
// reset (synchronous, active high) clears counts, flags, dimensions and handshakes;
// store contents stay undefined until written
module sparse_triplet_transpose
   import stt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   stt_req_if.sink                   req,
   stt_rsp_if.source                 rsp,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]       csr_wdata
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_HDR  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_PUT  = 2'd3;

   stt_entry_type entry_store [MAX_ENTRIES];

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [DIM_BITS-1:0] rows_ff, rows_in;
   logic [DIM_BITS-1:0] cols_ff, cols_in;

   logic [CNT_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [ADDR_BITS-1:0] rd_idx_ff;
   stt_entry_type        rd_data_ff;

   logic                best_valid_ff, best_valid_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;
   stt_entry_type       best_entry_ff, best_entry_in;
   logic                have_prev_ff, have_prev_in;
   logic [KEY_BITS-1:0] prev_key_ff, prev_key_in;
   logic [CNT_BITS-1:0] emit_cnt_ff, emit_cnt_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hdr_ff, rsp_hdr_in;
   logic [DIM_BITS-1:0]          rsp_row_ff, rsp_row_in;
   logic [DIM_BITS-1:0]          rsp_col_ff, rsp_col_in;
   logic signed [VALUE_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                req_fire;
   logic                has_room;
   logic                store_wr;
   logic                out_free;
   logic                issue;
   logic [KEY_BITS-1:0] cand_key;
   logic                take;
   logic                scan_done;
   logic                emit_last;

   assign req.ready   = (state_ff == ST_LOAD);
   assign req_fire    = req.valid && req.ready;
   assign has_room    = (count_ff < CNT_BITS'(MAX_ENTRIES));
   assign store_wr    = req_fire && has_room;
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign issue       = (state_ff == ST_SCAN) && (rd_addr_ff < count_ff);
   assign cand_key    = {rd_data_ff.col_index, rd_idx_ff};
   assign take        = rd_valid_ff && (!have_prev_ff || (cand_key > prev_key_ff))
                        && (!best_valid_ff || (cand_key < best_key_ff));
   assign scan_done   = rd_valid_ff && ((CNT_BITS'(rd_idx_ff) + CNT_BITS'(1)) == count_ff);
   assign emit_last   = ((emit_cnt_ff + CNT_BITS'(1)) == count_ff);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.is_header   = rsp_hdr_ff;
   assign rsp.out_row     = rsp_row_ff;
   assign rsp.out_col     = rsp_col_ff;
   assign rsp.out_value   = rsp_val_ff;
   assign rsp.overflowed  = rsp_ovf_ff;
   assign rsp.last_result = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      rd_addr_in    = rd_addr_ff;
      rd_valid_in   = issue;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      best_entry_in = best_entry_ff;
      have_prev_in  = have_prev_ff;
      prev_key_in   = prev_key_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_hdr_in    = rsp_hdr_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MATRIX_ROWS: rows_in = csr_wdata;
            CSR_MATRIX_COLS: cols_in = csr_wdata;
         endcase
      end

      if (issue) begin
         rd_addr_in = rd_addr_ff + CNT_BITS'(1);
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req.last_entry) begin
                  state_in = ST_HDR;
               end
            end
         end
         ST_HDR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hdr_in    = 1'b1;
               rsp_row_in    = cols_ff;
               rsp_col_in    = rows_ff;
               rsp_val_in    = VALUE_BITS'(count_ff);
               rsp_ovf_in    = ovf_ff;
               rsp_last_in   = (count_ff == '0);
               rd_addr_in    = '0;
               best_valid_in = 1'b0;
               have_prev_in  = 1'b0;
               emit_cnt_in   = '0;
               if (count_ff == '0) begin
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               best_valid_in = 1'b1;
               best_key_in   = cand_key;
               best_entry_in = rd_data_ff;
            end
            if (scan_done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hdr_in    = 1'b0;
               rsp_row_in    = DIM_BITS'(best_entry_ff.col_index);
               rsp_col_in    = DIM_BITS'(best_entry_ff.row_index);
               rsp_val_in    = best_entry_ff.entry_value;
               rsp_ovf_in    = 1'b0;
               rsp_last_in   = emit_last;
               have_prev_in  = 1'b1;
               prev_key_in   = best_key_ff;
               best_valid_in = 1'b0;
               emit_cnt_in   = emit_cnt_ff + CNT_BITS'(1);
               rd_addr_in    = '0;
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rows_ff       <= '0;
         cols_ff       <= '0;
         rd_addr_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         have_prev_ff  <= 1'b0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         rd_addr_ff    <= rd_addr_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         have_prev_ff  <= have_prev_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff   <= best_key_in;
      best_entry_ff <= best_entry_in;
      prev_key_ff   <= prev_key_in;
      rsp_hdr_ff    <= rsp_hdr_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_wr) begin
         entry_store[count_ff[ADDR_BITS-1:0]] <= '{row_index:   req.row_index,
                                                   col_index:   req.col_index,
                                                   entry_value: req.entry_value};
      end
      rd_data_ff <= entry_store[rd_addr_ff[ADDR_BITS-1:0]];
      rd_idx_ff  <= rd_addr_ff[ADDR_BITS-1:0];
   end

endmodule
